@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the instruction decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/c8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// c8dec_pkg
// Operation codes, instruction word constants and the decode result type.
// ----------------------------------------------------------------------------
package c8dec_pkg;

  // Dense operation numbers
  typedef enum logic [5:0] {
    OP_NOP      = 6'd0,
    OP_CLS      = 6'd1,
    OP_RET      = 6'd2,
    OP_EXIT     = 6'd3,
    OP_SCR      = 6'd4,
    OP_SCL      = 6'd5,
    OP_SCD      = 6'd6,
    OP_LOW      = 6'd7,
    OP_HIGH     = 6'd8,
    OP_SYS      = 6'd9,
    OP_JP       = 6'd10,
    OP_CALL     = 6'd11,
    OP_SE_VB    = 6'd12,
    OP_SNE_VB   = 6'd13,
    OP_SE_VV    = 6'd14,
    OP_LD_VB    = 6'd15,
    OP_ADD_VB   = 6'd16,
    OP_LD_VV    = 6'd17,
    OP_OR       = 6'd18,
    OP_AND      = 6'd19,
    OP_XOR      = 6'd20,
    OP_ADD_VV   = 6'd21,
    OP_SUB      = 6'd22,
    OP_SHR      = 6'd23,
    OP_SUBN     = 6'd24,
    OP_SHL      = 6'd25,
    OP_SNE_VV   = 6'd26,
    OP_LD_I     = 6'd27,
    OP_JP_V0    = 6'd28,
    OP_RND      = 6'd29,
    OP_DRW      = 6'd30,
    OP_DRW_BIG  = 6'd31,
    OP_SKP      = 6'd32,
    OP_SKNP     = 6'd33,
    OP_LD_VDT   = 6'd34,
    OP_LD_KEY   = 6'd35,
    OP_LD_DTV   = 6'd36,
    OP_LD_STV   = 6'd37,
    OP_ADD_I    = 6'd38,
    OP_LD_FONT  = 6'd39,
    OP_LD_HFONT = 6'd40,
    OP_BCD      = 6'd41,
    OP_STORE    = 6'd42,
    OP_LOAD     = 6'd43,
    OP_SAVE_FLG = 6'd44,
    OP_LOAD_FLG = 6'd45
  } op_e;

  // Top nibble groups
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEB  = 4'h3;
  localparam logic [3:0] GRP_SNEB = 4'h4;
  localparam logic [3:0] GRP_SEV  = 4'h5;
  localparam logic [3:0] GRP_LDB  = 4'h6;
  localparam logic [3:0] GRP_ADDB = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNEV = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;

  // Last ALU sub-opcode of the dense run, and the one beyond it
  localparam logic [3:0] ALU_LAST = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // Full row-zero words
  localparam logic [15:0] W_NOP      = 16'h0000;
  localparam logic [15:0] W_CLS      = 16'h00E0;
  localparam logic [15:0] W_RET      = 16'h00EE;
  localparam logic [15:0] W_EXIT     = 16'h00FD;
  localparam logic [15:0] W_SCR      = 16'h00FB;
  localparam logic [15:0] W_SCL      = 16'h00FC;
  localparam logic [15:0] W_LOW      = 16'h00FE;
  localparam logic [15:0] W_HIGH     = 16'h00FF;
  localparam logic [15:0] W_SCD      = 16'h00C0;
  localparam logic [15:0] W_SCD_MASK = 16'hFFF0;

  // E/F forms, compared with X masked off
  localparam logic [15:0] EF_MASK  = 16'hF0FF;
  localparam logic [15:0] EF_SKP   = 16'hE09E;
  localparam logic [15:0] EF_SKNP  = 16'hE0A1;
  localparam logic [15:0] EF_LDVDT = 16'hF007;
  localparam logic [15:0] EF_LDKEY = 16'hF00A;
  localparam logic [15:0] EF_LDDTV = 16'hF015;
  localparam logic [15:0] EF_LDSTV = 16'hF018;
  localparam logic [15:0] EF_ADDI  = 16'hF01E;
  localparam logic [15:0] EF_FONT  = 16'hF029;
  localparam logic [15:0] EF_HFONT = 16'hF030;
  localparam logic [15:0] EF_BCD   = 16'hF033;
  localparam logic [15:0] EF_STORE = 16'hF055;
  localparam logic [15:0] EF_LOAD  = 16'hF065;
  localparam logic [15:0] EF_SAVEF = 16'hF075;
  localparam logic [15:0] EF_LOADF = 16'hF085;

  // One decoded word
  typedef struct packed {
    op_e         operation;
    logic        valid_res;
    logic [3:0]  x_index;
    logic [3:0]  y_index;
    logic [7:0]  immediate;
    logic [3:0]  nibble;
    logic [11:0] address;
  } dec_res_t;

endpackage

@@ sv/chip8_instruction_decoder_core.sv @@
// ----------------------------------------------------------------------------
// chip8_instruction_decoder_core
// Decodes CHIP-8 / super instruction words, one word per clock.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  command   | start_i / busy_o   | instruction_i
//  result    | done_o (strobe)    | operation_o valid_res_o x_index_o
//            |                    | y_index_o immediate_o nibble_o address_o
//  config    | cfg_we_i           | cfg_wdata_i (super enable)
//
//  A word is taken on every edge with start_i high; busy_o stays low.
//  Each word passes the input register, then is decoded into the result register.
//  A new word may follow every cycle; the result strobe lasts one cycle.
//  Reset clears the pipeline valid flags and the super enable.
//  The receiver takes every result as it appears and never stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chip8_instruction_decoder_core
  import c8dec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] instruction_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output logic        done_o,
  output logic [5:0]  operation_o,
  output logic        valid_res_o,
  output logic [3:0]  x_index_o,
  output logic [3:0]  y_index_o,
  output logic [7:0]  immediate_o,
  output logic [3:0]  nibble_o,
  output logic [11:0] address_o
);

  logic        super_q;
  logic        in_vld_q;
  logic [15:0] word_q;
  logic        done_q;
  dec_res_t    res_d;
  dec_res_t    res_q;

  assign busy_o = 1'b0;

  // Hold the super enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      super_q <= 1'b0;
    end else if (cfg_we_i) begin
      super_q <= cfg_wdata_i;
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      word_q <= instruction_i;
    end
  end

  c8dec_decode u_decode (
    .word_i  (word_q),
    .super_i (super_q),
    .res_o   (res_d)
  );

  // Advance the decoded word into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o      = done_q;
  assign operation_o = res_q.operation;
  assign valid_res_o = res_q.valid_res;
  assign x_index_o   = res_q.x_index;
  assign y_index_o   = res_q.y_index;
  assign immediate_o = res_q.immediate;
  assign nibble_o    = res_q.nibble;
  assign address_o   = res_q.address;

  // Every accepted word reaches the input stage, then is strobed as a result
  `ASSERT_RST(a_accept_stage, clk_i, rst_ni, (start_i && !busy_o) |=> in_vld_q, "word lost at input stage")
  `ASSERT_RST(a_stage_done, clk_i, rst_ni, in_vld_q |=> done_o, "decoded word not strobed")
  // An invalid word reports no operation
  `ASSERT_RST(a_invalid_nop, clk_i, rst_ni, (done_o && !valid_res_o) |-> (operation_o == OP_NOP), "invalid word carries an operation")
  // Operand slices come from the same word
  `ASSERT_RST(a_slices, clk_i, rst_ni, done_o |-> (address_o[11:8] == x_index_o && immediate_o[3:0] == nibble_o && immediate_o[7:4] == y_index_o), "operand slices disagree")
  // The command side never stalls
  `ASSERT_ALWAYS(a_never_busy, clk_i, !busy_o, "busy raised")

endmodule

@@ sv/c8dec_decode.sv @@
// ----------------------------------------------------------------------------
// c8dec_decode
// Combinational decode of one instruction word into an operation and operands.
// ----------------------------------------------------------------------------
module c8dec_decode
  import c8dec_pkg::*;
(
  input  logic [15:0] word_i,
  input  logic        super_i,
  output dec_res_t    res_o
);

  logic [3:0]  top;
  logic [3:0]  low;
  logic [15:0] ef;
  op_e         op;
  logic        ok;

  assign top = word_i[15:12];
  assign low = word_i[3:0];
  assign ef  = word_i & EF_MASK;

  // Pick the operation by top nibble, then by the finer fields
  always_comb begin
    op = OP_NOP;
    ok = 1'b1;
    unique case (top)
      GRP_SYS: begin
        if (word_i == W_NOP)                          op = OP_NOP;
        else if (word_i == W_CLS)                     op = OP_CLS;
        else if (word_i == W_RET)                     op = OP_RET;
        else if (super_i && word_i == W_EXIT)         op = OP_EXIT;
        else if (word_i == W_SCR)                     op = OP_SCR;
        else if (word_i == W_SCL)                     op = OP_SCL;
        else if ((word_i & W_SCD_MASK) == W_SCD)      op = OP_SCD;
        else if (word_i == W_LOW)                     op = OP_LOW;
        else if (word_i == W_HIGH)                    op = OP_HIGH;
        else                                          op = OP_SYS;
      end
      GRP_JP:   op = OP_JP;
      GRP_CALL: op = OP_CALL;
      GRP_SEB:  op = OP_SE_VB;
      GRP_SNEB: op = OP_SNE_VB;
      GRP_SEV:  op = OP_SE_VV;
      GRP_LDB:  op = OP_LD_VB;
      GRP_ADDB: op = OP_ADD_VB;
      GRP_ALU: begin
        unique case (low) inside
          [4'h0:ALU_LAST]: op = op_e'(6'(OP_LD_VV) + {2'b00, low});
          ALU_SHL:         op = OP_SHL;
          default:         ok = 1'b0;
        endcase
      end
      GRP_SNEV: op = OP_SNE_VV;
      GRP_LDI:  op = OP_LD_I;
      GRP_JPV0: op = OP_JP_V0;
      GRP_RND:  op = OP_RND;
      GRP_DRW:  op = (super_i && low == 4'h0) ? OP_DRW_BIG : OP_DRW;
      default: begin
        // E and F rows: match with X masked off
        if (ef == EF_SKP)                       op = OP_SKP;
        else if (ef == EF_SKNP)                 op = OP_SKNP;
        else if (ef == EF_LDVDT)                op = OP_LD_VDT;
        else if (ef == EF_LDKEY)                op = OP_LD_KEY;
        else if (ef == EF_LDDTV)                op = OP_LD_DTV;
        else if (ef == EF_LDSTV)                op = OP_LD_STV;
        else if (ef == EF_ADDI)                 op = OP_ADD_I;
        else if (ef == EF_FONT)                 op = OP_LD_FONT;
        else if (super_i && ef == EF_HFONT)     op = OP_LD_HFONT;
        else if (ef == EF_BCD)                  op = OP_BCD;
        else if (ef == EF_STORE)                op = OP_STORE;
        else if (ef == EF_LOAD)                 op = OP_LOAD;
        else if (super_i && ef == EF_SAVEF)     op = OP_SAVE_FLG;
        else if (super_i && ef == EF_LOADF)     op = OP_LOAD_FLG;
        else                                    ok = 1'b0;
        // flag storage only covers V0..V7
        if ((op == OP_SAVE_FLG || op == OP_LOAD_FLG) && word_i[11]) begin
          ok = 1'b0;
        end
      end
    endcase
  end

  // Drop the operation of an invalid word, slice the operands always
  always_comb begin
    res_o.operation = ok ? op : OP_NOP;
    res_o.valid_res = ok;
    res_o.x_index   = word_i[11:8];
    res_o.y_index   = word_i[7:4];
    res_o.immediate = word_i[7:0];
    res_o.nibble    = word_i[3:0];
    res_o.address   = word_i[11:0];
  end

endmodule
